// ===== design/clecc_pkg.sv =====
// Package: payload types, status and action codes, and the shared code functions.
`timescale 1ns / 1ps

package clecc_pkg;

    // Action codes carried in the input word.
    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    // Status codes carried in the result word.
    localparam logic [1:0] STATUS_CLEAN   = 2'd0;
    localparam logic [1:0] STATUS_FIXED   = 2'd1;
    localparam logic [1:0] STATUS_UNCORR  = 2'd2;

    // Codes returned by the syndrome decoder: 0 to 7 name a data bit.
    localparam logic [3:0] TGT_CHECK   = 4'd8;
    localparam logic [3:0] TGT_INVALID = 4'd9;

    // Input word.
    typedef struct packed {
        logic        action;
        logic [31:0] data_word;
        logic [31:0] check_word;
        logic        extra_parity;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [31:0] data_out;
        logic [31:0] check_out;
        logic        parity_out;
        logic [1:0]  status;
    } out_word_t;

    // Syndromes of one word, passed from the syndrome stage to the correction stage.
    typedef struct packed {
        logic [3:0][3:0] row_cb;   // Hamming syndrome per byte row
        logic [3:0]      row_pa;   // overall row parity syndrome
        logic [7:0]      col_data; // data column syndromes
        logic [3:0]      col_chk;  // check-bit column syndromes
        logic            extra;    // syndrome of the parity over the row parities
    } synd_t;

    // Fresh check bits of one word.
    typedef struct packed {
        logic [31:0] check;
        logic        parity;
    } enc_t;

    // Four Hamming bits of one byte.
    function automatic logic [3:0] row_ham(input logic [7:0] b);
        return {^(b & 8'hF0), ^(b & 8'h8E), ^(b & 8'h6D), ^(b & 8'h5B)};
    endfunction

    // Maps a Hamming syndrome onto the bit it addresses.
    function automatic logic [3:0] syn_target(input logic [3:0] s);
        logic [3:0] t;
        case (s)
            4'd3:    t = 4'd0;
            4'd5:    t = 4'd1;
            4'd6:    t = 4'd2;
            4'd7:    t = 4'd3;
            4'd9:    t = 4'd4;
            4'd10:   t = 4'd5;
            4'd11:   t = 4'd6;
            4'd12:   t = 4'd7;
            4'd13,
            4'd14,
            4'd15:   t = TGT_INVALID;
            default: t = TGT_CHECK;
        endcase
        return t;
    endfunction

    // Builds the check word and extra parity from a data word.
    function automatic enc_t encode_word(input logic [31:0] d);
        enc_t       e;
        logic [7:0] b;
        logic [3:0] h;
        e = '0;
        for (int k = 0; k < 4; k++) begin
            b = d[8*k +: 8];
            h = row_ham(b);
            e.check[5*k +: 4] = h;
            e.check[5*k + 4]  = ^{h, b};
        end
        for (int k = 0; k < 8; k++) begin
            e.check[20 + k] = d[k] ^ d[k + 8] ^ d[k + 16] ^ d[k + 24];
        end
        for (int k = 0; k < 4; k++) begin
            e.check[28 + k] = e.check[k] ^ e.check[k + 5] ^ e.check[k + 10]
                            ^ e.check[k + 15];
        end
        e.parity = e.check[4] ^ e.check[9] ^ e.check[14] ^ e.check[19];
        return e;
    endfunction

endpackage

// ===== design/clecc_syndrome.sv =====
// Syndrome generator: compares stored check bits against those rebuilt from the data.
`timescale 1ns / 1ps

module clecc_syndrome
    import clecc_pkg::*;
(
    input  logic [31:0] data_word,
    input  logic [31:0] check_word,
    input  logic        extra_parity,
    output synd_t       synd
);

    // Row, column and extra parity syndromes.
    always_comb begin
        synd = '0;
        for (int k = 0; k < 4; k++) begin
            synd.row_cb[k] = check_word[5*k +: 4] ^ row_ham(data_word[8*k +: 8]);
            synd.row_pa[k] = ^check_word[5*k +: 5] ^ ^data_word[8*k +: 8];
        end
        for (int k = 0; k < 8; k++) begin
            synd.col_data[k] = data_word[k] ^ data_word[k + 8] ^ data_word[k + 16]
                             ^ data_word[k + 24] ^ check_word[20 + k];
        end
        for (int k = 0; k < 4; k++) begin
            synd.col_chk[k] = check_word[k] ^ check_word[k + 5] ^ check_word[k + 10]
                            ^ check_word[k + 15] ^ check_word[28 + k];
        end
        synd.extra = check_word[4] ^ check_word[9] ^ check_word[14] ^ check_word[19]
                   ^ extra_parity;
    end

endmodule

// ===== design/clecc_correct.sv =====
// Error classifier and data corrector, driven by the syndromes of one word.
`timescale 1ns / 1ps

module clecc_correct
    import clecc_pkg::*;
(
    input  logic        action,
    input  logic [31:0] data_word,
    input  synd_t       synd,
    output logic [31:0] data_out,
    output logic [1:0]  status
);

    logic [3:0]  row_cb_nz;
    logic [3:0]  row_any;
    logic        scb;
    logic        spa;
    logic        sp;
    logic [31:0] col_fix;
    logic [31:0] ham_fix;
    logic        ham_bad;
    logic [3:0]  tgt;

    // Summary flags over the rows and columns.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            row_cb_nz[k] = |synd.row_cb[k];
            row_any[k]   = row_cb_nz[k] | synd.row_pa[k];
        end
        scb = |row_cb_nz;
        spa = |synd.row_pa;
        sp  = (|synd.col_data) | (|synd.col_chk) | synd.extra;
    end

    // Column correction and per-row Hamming correction, both formed in parallel.
    always_comb begin
        col_fix = data_word;
        ham_fix = data_word;
        ham_bad = 1'b0;
        tgt     = '0;
        for (int k = 0; k < 4; k++) begin
            if (row_any[k]) begin
                col_fix[8*k +: 8] = data_word[8*k +: 8] ^ synd.col_data;
            end
            tgt = syn_target(synd.row_cb[k]);
            if (row_cb_nz[k]) begin
                if (!synd.row_pa[k] || tgt == TGT_INVALID) begin
                    ham_bad = 1'b1;
                end else if (tgt != TGT_CHECK) begin
                    ham_fix[8*k +: 8] = data_word[8*k +: 8] ^ (8'd1 << tgt[2:0]);
                end
            end
        end
    end

    // Outcome selection from the SCB, SPa and SP flags.
    always_comb begin
        data_out = data_word;
        status   = STATUS_CLEAN;
        if (action == ACT_DECODE) begin
            if (!scb && !spa && !sp) begin
                status = STATUS_CLEAN;
            end else if ((spa && !scb && !sp) || (scb && !spa && !sp)) begin
                status = STATUS_UNCORR;
            end else if ((spa && sp && !scb) || (scb && sp && !spa)
                         || (scb && spa && sp && $onehot(row_cb_nz))) begin
                data_out = col_fix;
                status   = STATUS_FIXED;
            end else if (ham_bad) begin
                status = STATUS_UNCORR;
            end else begin
                data_out = ham_fix;
                status   = STATUS_FIXED;
            end
        end
    end

endmodule

// ===== design/column_line_ecc_codec_unit.sv =====
// Top level: three-stage column/line ECC encoder and checker for 32-bit words.
`timescale 1ns / 1ps

// Column/line ECC codec for one 32-bit data word with a 32-bit check word.
// Input channel s_valid/s_ready/s_payload carries the action, the data word,
// the stored check word and the stored extra parity. With action encode the
// stored check bits are ignored and fresh ones are built from the data.
// With action decode the syndromes are formed, the data is corrected where
// the error pattern allows, and the result is re-encoded.
// Result channel m_valid/m_ready/m_payload returns the data, the fresh check
// word, the fresh extra parity and a status (clean, corrected, uncorrectable).
// Each input word gives exactly one result word.
// From acceptance to m_valid each word passes through the syndrome stage,
// the correction stage and the re-encoding stage, each ending in a register.
// Throughput is one word per cycle while m_ready stays high; the pipeline is fully overlapped.
// When the receiver holds m_ready low, the stages fill up and s_ready falls
// once all three hold a word; nothing is lost or repeated.
// A synchronous active-low reset on aresetn empties the pipeline.

module column_line_ecc_codec_unit
    import clecc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_payload
);

    // Stage valid bits and stage enables.
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic en1, en2, en3;

    // Stage one: syndromes.
    logic        act1_reg;
    logic [31:0] data1_reg;
    synd_t       synd1_reg;
    synd_t       synd_next;

    // Stage two: corrected data and status.
    logic [31:0] data2_reg;
    logic [1:0]  status2_reg;
    logic [31:0] fix_data;
    logic [1:0]  fix_status;

    // Stage three: result word.
    out_word_t out_reg;
    enc_t      enc;

    // A stage takes a new word when it is empty or its word moves on.
    always_comb begin
        en3     = !v3_reg || m_ready;
        en2     = !v2_reg || en3;
        en1     = !v1_reg || en2;
        s_ready = en1;
        v1_next = en1 ? s_valid : v1_reg;
        v2_next = en2 ? v1_reg  : v2_reg;
        v3_next = en3 ? v2_reg  : v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Syndrome stage.
    clecc_syndrome u_syndrome (
        .data_word    (s_payload.data_word),
        .check_word   (s_payload.check_word),
        .extra_parity (s_payload.extra_parity),
        .synd         (synd_next)
    );

    always_ff @(posedge aclk) begin
        if (en1) begin
            act1_reg  <= s_payload.action;
            data1_reg <= s_payload.data_word;
            synd1_reg <= synd_next;
        end
    end

    // Correction stage.
    clecc_correct u_correct (
        .action    (act1_reg),
        .data_word (data1_reg),
        .synd      (synd1_reg),
        .data_out  (fix_data),
        .status    (fix_status)
    );

    always_ff @(posedge aclk) begin
        if (en2) begin
            data2_reg   <= fix_data;
            status2_reg <= fix_status;
        end
    end

    // Re-encoding stage.
    always_comb begin
        enc = encode_word(data2_reg);
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            out_reg.data_out   <= data2_reg;
            out_reg.check_out  <= enc.check;
            out_reg.parity_out <= enc.parity;
            out_reg.status     <= status2_reg;
        end
    end

    assign m_valid   = v3_reg;
    assign m_payload = out_reg;

endmodule
